// ===== rtl/ddcm_pkg.sv =====
`default_nettype none

package ddcm_pkg;

  localparam int unsigned LevelW = 13;
  localparam int unsigned RegW   = 12;
  localparam int unsigned CmdW   = 16;
  localparam int unsigned MagW   = CmdW + 1;
  localparam int unsigned FracW  = 15;
  localparam int unsigned ProdW  = MagW + LevelW;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LevelW-1:0] LevelMax = '1;
  localparam logic [MagW-1:0]   QOne     = MagW'(32768);

  localparam logic [RegW-1:0] NormalGainRst  = RegW'(1287);
  localparam logic [RegW-1:0] TurboGainRst   = RegW'(3000);
  localparam logic [RegW-1:0] DriveOffsetRst = RegW'(1300);
  localparam logic [RegW-1:0] SpinGainRst    = RegW'(1750);
  localparam logic [RegW-1:0] IdleLevelRst   = RegW'(1000);

  typedef enum logic [1:0] {
    OP_VELOCITY = 2'd0,
    OP_SPEED_R  = 2'd1,
    OP_SPEED_L  = 2'd2,
    OP_BUTTONS  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NORMAL_GAIN  = 3'd0,
    CFG_TURBO_GAIN   = 3'd1,
    CFG_DRIVE_OFFSET = 3'd2,
    CFG_SPIN_GAIN    = 3'd3,
    CFG_IDLE_LEVEL   = 3'd4
  } cfg_idx_e;

  // relay bits: fwd right, fwd left, rev right, rev left
  localparam logic [3:0] RelayFwd  = 4'b0011;
  localparam logic [3:0] RelayRevR = 4'b0100;
  localparam logic [3:0] RelayRevL = 4'b1000;
  localparam logic [3:0] RelayRev  = 4'b1100;

  function automatic logic [MagW-1:0] abs_cmd(input logic signed [CmdW-1:0] v);
    logic signed [MagW-1:0] w;
    w = MagW'(v);
    return v[CmdW-1] ? MagW'(-w) : MagW'(w);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/diff_drive_command_mixer_core.sv =====
// Channel  | Dir | Payload (low bit up)
// s_axis   | in  | tuser: operation; tdata: linear_cmd, angular_cmd, speed_value,
//          |     |   turbo_button, brake_button, zero pad
// m_axis   | out | tdata: drive_right, drive_left, fwd_relay_right, fwd_relay_left,
//          |     |   rev_relay_right, rev_relay_left, brake_right, brake_left
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Speed, button, idle and blocked velocity events go from the idle state straight to the
// final state. Velocity commands use one shared 17x13 multiplier: a straight or
// point-turn command passes MUL1, a turn passes MUL1 and MUL2 (two chained multiplies).
// One event in flight; s_axis_tready_o is high only while the sequencer idles.
// A held result stalls the sequencer in its final state until m_axis takes it.
// rst_ni clears all state and restores the register defaults.
`default_nettype none

module diff_drive_command_mixer_core
  import ddcm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // linear_cmd, angular_cmd, speed_value, turbo_button, brake_button, pad
  input  wire logic [55:0]        s_axis_tdata_i,
  // operation
  input  wire logic [1:0]         s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // drive_right, drive_left, fwd_r, fwd_l, rev_r, rev_l, brake_r, brake_l
  output logic [31:0]             m_axis_tdata_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [RegW-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [RegW-1:0] normal_gain_q, turbo_gain_q, drive_offset_q, spin_gain_q, idle_level_q;

  logic signed [CmdW-1:0] right_speed_q, left_speed_q;
  logic                   turbo_on_q, brake_held_q;
  logic [LevelW-1:0]      right_level_q, left_level_q;
  logic [3:0]             relay_q;
  logic [1:0]             brake_q;

  logic [MagW-1:0]    mag_q;
  logic [FracW:0]     fac_q;
  logic               spin_q, turn_q, turn_left_q;
  logic [LevelW-1:0]  base_q;

  logic               out_valid_q;
  logic [31:0]        out_data_q;

  // input fields
  op_e                    op;
  logic signed [CmdW-1:0] lin, ang, spd;
  logic                   turbo_b, brake_b;

  assign op      = op_e'(s_axis_tuser_i);
  assign lin     = s_axis_tdata_i[15:0];
  assign ang     = s_axis_tdata_i[31:16];
  assign spd     = s_axis_tdata_i[47:32];
  assign turbo_b = s_axis_tdata_i[48];
  assign brake_b = s_axis_tdata_i[49];

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  logic speeds_zero;
  assign speeds_zero = (right_speed_q == '0) && (left_speed_q == '0);

  // shared multiplier
  logic [RegW-1:0]   gain_sel;
  logic [MagW-1:0]   mul_a;
  logic [LevelW-1:0] mul_b;
  logic [ProdW-1:0]  prod;
  logic [FracW-1:0]  prod_sh;
  logic [FracW:0]    base_sum;
  logic [LevelW-1:0] base_sat;

  always_comb begin
    gain_sel = spin_q ? spin_gain_q : (turbo_on_q ? turbo_gain_q : normal_gain_q);
    if (state_q == ST_MUL2) begin
      mul_a = MagW'(fac_q);
      mul_b = base_q;
    end else begin
      mul_a = mag_q;
      mul_b = LevelW'(gain_sel);
    end
    prod     = ProdW'(mul_a) * ProdW'(mul_b);
    prod_sh  = prod[ProdW-1-:FracW];
    base_sum = (FracW+1)'(prod_sh) + (FracW+1)'(drive_offset_q);
    base_sat = (base_sum > (FracW+1)'(LevelMax)) ? LevelMax : LevelW'(base_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      normal_gain_q  <= NormalGainRst;
      turbo_gain_q   <= TurboGainRst;
      drive_offset_q <= DriveOffsetRst;
      spin_gain_q    <= SpinGainRst;
      idle_level_q   <= IdleLevelRst;
      right_speed_q  <= '0;
      left_speed_q   <= '0;
      turbo_on_q     <= 1'b0;
      brake_held_q   <= 1'b0;
      right_level_q  <= '0;
      left_level_q   <= '0;
      relay_q        <= '0;
      brake_q        <= '0;
      mag_q          <= '0;
      fac_q          <= '0;
      spin_q         <= 1'b0;
      turn_q         <= 1'b0;
      turn_left_q    <= 1'b0;
      base_q         <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NORMAL_GAIN:  normal_gain_q  <= cfg_data_i;
          CFG_TURBO_GAIN:   turbo_gain_q   <= cfg_data_i;
          CFG_DRIVE_OFFSET: drive_offset_q <= cfg_data_i;
          CFG_SPIN_GAIN:    spin_gain_q    <= cfg_data_i;
          CFG_IDLE_LEVEL:   idle_level_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            spin_q      <= (lin == '0);
            turn_q      <= (ang != '0);
            turn_left_q <= !ang[CmdW-1];
            fac_q       <= (FracW+1)'(QOne - abs_cmd(ang));
            case (op)
              OP_VELOCITY: begin
                if (lin != '0) begin
                  mag_q <= abs_cmd(lin);
                  if (!lin[CmdW-1]) begin
                    if (!right_speed_q[CmdW-1] && !left_speed_q[CmdW-1]) begin
                      relay_q <= relay_q | RelayFwd;
                      state_q <= ST_MUL1;
                    end else begin
                      brake_q <= 2'b11;
                      state_q <= ST_DONE;
                    end
                  end else begin
                    if ((right_speed_q[CmdW-1] || right_speed_q == '0) &&
                        (left_speed_q[CmdW-1] || left_speed_q == '0)) begin
                      relay_q <= relay_q | RelayRev;
                      state_q <= ST_MUL1;
                    end else begin
                      brake_q <= 2'b11;
                      state_q <= ST_DONE;
                    end
                  end
                end else if (ang != '0) begin
                  mag_q <= abs_cmd(ang);
                  if (speeds_zero) begin
                    relay_q <= relay_q | (ang[CmdW-1] ? RelayRevR : RelayRevL);
                    state_q <= ST_MUL1;
                  end else begin
                    state_q <= ST_DONE;
                  end
                end else begin
                  relay_q       <= speeds_zero ? RelayFwd : (relay_q | RelayFwd);
                  right_level_q <= LevelW'(idle_level_q);
                  left_level_q  <= LevelW'(idle_level_q);
                  brake_q       <= {2{brake_held_q}};
                  state_q       <= ST_DONE;
                end
              end
              OP_SPEED_R: begin
                right_speed_q <= spd;
                state_q       <= ST_DONE;
              end
              OP_SPEED_L: begin
                left_speed_q <= spd;
                state_q      <= ST_DONE;
              end
              OP_BUTTONS: begin
                turbo_on_q   <= turbo_b;
                brake_held_q <= brake_b;
                brake_q      <= {2{brake_b &&
                                   right_level_q == LevelW'(idle_level_q) &&
                                   left_level_q  == LevelW'(idle_level_q)}};
                state_q      <= ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_MUL1: begin
          base_q        <= base_sat;
          right_level_q <= base_sat;
          left_level_q  <= base_sat;
          state_q       <= (turn_q && !spin_q) ? ST_MUL2 : ST_DONE;
        end
        ST_MUL2: begin
          if (turn_left_q) begin
            left_level_q <= LevelW'(prod_sh);
          end else begin
            right_level_q <= LevelW'(prod_sh);
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {brake_q[1], brake_q[0], relay_q[3], relay_q[2],
                            relay_q[1], relay_q[0], left_level_q, right_level_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_mul2_after_mul1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL2 |-> $past(state_q) == ST_MUL1)
    else $error("second multiply without first");

  a_no_spin_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL2 |-> !spin_q && turn_q)
    else $error("turn multiply on a point turn");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("transfer accepted without work");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_DONE)
    else $error("result loaded outside final state");

endmodule

`default_nettype wire

// ===== tb/ddcm_checker.sv =====
`timescale 1ns / 100ps

module ddcm_checker
  import ddcm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  // linear_cmd, angular_cmd, speed_value, turbo_button, brake_button, pad
  input  logic [55:0]        s_axis_tdata_i,
  // operation
  input  logic [1:0]         s_axis_tuser_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  // drive_right, drive_left, fwd_r, fwd_l, rev_r, rev_l, brake_r, brake_l
  input  logic [31:0]        m_axis_tdata_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  output int unsigned        failures_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic              brk_left;
    logic              brk_right;
    logic              rev_left;
    logic              rev_right;
    logic              fwd_left;
    logic              fwd_right;
    logic [LevelW-1:0] drive_left;
    logic [LevelW-1:0] drive_right;
  } snapshot_t;

  localparam logic [1:0] BrakesOn  = 2'b11;
  localparam logic [1:0] BrakesOff = 2'b00;

  logic [RegW-1:0] normal_gain, turbo_gain, drive_offset, spin_gain, idle_level;
  int              right_speed, left_speed;
  logic            turbo_on, brake_held;
  int unsigned     right_level, left_level;
  logic [3:0]      relay_flags;
  logic [1:0]      brake_flags;

  snapshot_t expected_snaps[$];
  snapshot_t got, want;

  function automatic int unsigned clamp_level(int unsigned v);
    return (v > int'(LevelMax)) ? int'(LevelMax) : v;
  endfunction

  // straight level from the linear magnitude, inner wheel cut for a turn
  task automatic mix_drive(input int unsigned mag, input int yv);
    int unsigned gain, base, rest;
    gain = turbo_on ? turbo_gain : normal_gain;
    base = clamp_level(((mag * gain) >> FracW) + drive_offset);
    right_level = base;
    left_level  = base;
    if (yv > 0) begin
      rest = int'(QOne) - yv;
      left_level = (base * rest) >> FracW;
    end else if (yv < 0) begin
      rest = int'(QOne) + yv;
      right_level = (base * rest) >> FracW;
    end
  endtask

  task automatic apply_velocity(input int xv, input int yv);
    int unsigned mag;
    if (xv > 0) begin
      if (right_speed >= 0 && left_speed >= 0) begin
        relay_flags |= RelayFwd;
        mix_drive(xv, yv);
      end else begin
        brake_flags = BrakesOn;
      end
    end else if (xv < 0) begin
      if (right_speed <= 0 && left_speed <= 0) begin
        relay_flags |= RelayRev;
        mix_drive(-xv, yv);
      end else begin
        brake_flags = BrakesOn;
      end
    end else if (yv != 0) begin
      // point turn only at standstill
      if (right_speed == 0 && left_speed == 0) begin
        mag = (yv > 0) ? yv : -yv;
        right_level = clamp_level(((mag * spin_gain) >> FracW) + drive_offset);
        left_level  = right_level;
        relay_flags |= (yv > 0) ? RelayRevL : RelayRevR;
      end
    end else begin
      relay_flags |= RelayFwd;
      right_level = idle_level;
      left_level  = idle_level;
      brake_flags = brake_held ? BrakesOn : BrakesOff;
      if (right_speed == 0 && left_speed == 0) relay_flags &= RelayFwd;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_gain  = NormalGainRst;
      turbo_gain   = TurboGainRst;
      drive_offset = DriveOffsetRst;
      spin_gain    = SpinGainRst;
      idle_level   = IdleLevelRst;
      right_speed  = 0;
      left_speed   = 0;
      turbo_on     = 1'b0;
      brake_held   = 1'b0;
      right_level  = 0;
      left_level   = 0;
      relay_flags  = '0;
      brake_flags  = BrakesOff;
      expected_snaps.delete();
      failures_o   = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = snapshot_t'(m_axis_tdata_i);
        if (expected_snaps.size() == 0) begin
          failures_o++;
          if (failures_o <= 10)
            $display("%0t: result transfer with nothing expected: R=%0d L=%0d data=%h",
                     $time, got.drive_right, got.drive_left, m_axis_tdata_i);
        end else begin
          want = expected_snaps.pop_front();
          if (got !== want) begin
            failures_o++;
            // flags from the top: brk l/r, rev l/r, fwd l/r
            if (failures_o <= 10)
              $display("%0t: snapshot mismatch: want R=%0d L=%0d flags=%b, got R=%0d L=%0d flags=%b",
                       $time, want.drive_right, want.drive_left, want[31:26],
                       got.drive_right, got.drive_left, got[31:26]);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORMAL_GAIN:  normal_gain  = cfg_data_i;
          CFG_TURBO_GAIN:   turbo_gain   = cfg_data_i;
          CFG_DRIVE_OFFSET: drive_offset = cfg_data_i;
          CFG_SPIN_GAIN:    spin_gain    = cfg_data_i;
          CFG_IDLE_LEVEL:   idle_level   = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        case (op_e'(s_axis_tuser_i))
          OP_VELOCITY: apply_velocity(int'($signed(s_axis_tdata_i[15:0])),
                                      int'($signed(s_axis_tdata_i[31:16])));
          OP_SPEED_R:  right_speed = int'($signed(s_axis_tdata_i[47:32]));
          OP_SPEED_L:  left_speed  = int'($signed(s_axis_tdata_i[47:32]));
          default: begin
            turbo_on   = s_axis_tdata_i[48];
            brake_held = s_axis_tdata_i[49];
            brake_flags = (brake_held && right_level == idle_level &&
                           left_level == idle_level) ? BrakesOn : BrakesOff;
          end
        endcase
        want.drive_right = LevelW'(right_level);
        want.drive_left  = LevelW'(left_level);
        want.fwd_right   = relay_flags[0];
        want.fwd_left    = relay_flags[1];
        want.rev_right   = relay_flags[2];
        want.rev_left    = relay_flags[3];
        want.brk_right   = brake_flags[0];
        want.brk_left    = brake_flags[1];
        expected_snaps.push_back(want);
      end

      pending_o = expected_snaps.size();
    end
  end

endmodule

// ===== tb/diff_drive_command_mixer_core_test.sv =====
`timescale 1ns / 100ps

module diff_drive_command_mixer_core_test;
  import ddcm_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               s_valid;
  logic               s_ready;
  logic [55:0]        s_data;
  logic [1:0]         s_user;
  logic               m_valid;
  logic               m_ready;
  logic [31:0]        m_data;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RegW-1:0]    cfg_data;

  int unsigned failures;
  int unsigned pending;
  int          burst_left;
  bit          holdoff_req;

  diff_drive_command_mixer_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  ddcm_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .failures_o      (failures),
    .pending_o       (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] rnd_cmd();
    logic [15:0] pick;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: pick = 16'h7fff;
        1: pick = 16'h8000;
        2: pick = 16'h0001;
        default: pick = 16'hffff;
      endcase
    end else begin
      pick = 16'($urandom);
    end
    return pick;
  endfunction

  function automatic logic [15:0] rnd_speed();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 16'd0;
    if (sel < 60) return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 300))
                                                      : 16'(-$urandom_range(1, 300));
    return 16'($urandom);
  endfunction

  // one transfer on the event channel; bursts with random gaps between them
  task automatic send_event(input op_e op, input logic [15:0] lin, input logic [15:0] ang,
                            input logic [15:0] spd, input logic turbo, input logic brake);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        s_valid <= 1'b0;
        s_data  <= 56'({$urandom, $urandom});
        s_user  <= 2'($urandom);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {6'd0, brake, turbo, spd, ang, lin};
    do @(posedge clk); while (!s_ready);
    burst_left--;
  endtask

  task automatic send_velocity(input logic [15:0] lin, input logic [15:0] ang);
    send_event(OP_VELOCITY, lin, ang, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_speed(input op_e op, input logic [15:0] spd);
    send_event(op, 16'($urandom), 16'($urandom), spd, 1'($urandom), 1'($urandom));
  endtask

  task automatic send_buttons(input logic turbo, input logic brake);
    send_event(OP_BUTTONS, 16'($urandom), 16'($urandom), 16'($urandom), turbo, brake);
  endtask

  task automatic random_velocity();
    int sel;
    logic [15:0] lin, ang;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      lin = 16'd0;
      ang = 16'd0;
    end else if (sel < 26) begin
      lin = 16'd0;
      ang = rnd_cmd();
      if (ang == 16'd0) ang = 16'h8000;
    end else begin
      lin = rnd_cmd();
      if (lin == 16'd0) lin = 16'h7fff;
      ang = ($urandom_range(0, 9) < 3) ? 16'd0 : rnd_cmd();
    end
    send_velocity(lin, ang);
  endtask

  task automatic random_event();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // bring both wheels to rest, then command
      send_speed(OP_SPEED_R, 16'd0);
      send_speed(OP_SPEED_L, 16'd0);
      random_velocity();
    end else if (sel < 20) begin
      send_speed(OP_SPEED_R, rnd_speed());
    end else if (sel < 32) begin
      send_speed(OP_SPEED_L, rnd_speed());
    end else if (sel < 45) begin
      send_buttons(1'($urandom), 1'($urandom));
    end else begin
      random_velocity();
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= RegW'($urandom);
  endtask

  task automatic apply_settings(input logic [RegW-1:0] ng, input logic [RegW-1:0] tg,
                                input logic [RegW-1:0] off, input logic [RegW-1:0] sg,
                                input logic [RegW-1:0] idle);
    wait_drained();
    write_reg(CFG_NORMAL_GAIN, ng);
    write_reg(CFG_TURBO_GAIN, tg);
    write_reg(CFG_DRIVE_OFFSET, off);
    write_reg(CFG_SPIN_GAIN, sg);
    write_reg(CFG_IDLE_LEVEL, idle);
  endtask

  task automatic run_directed();
    send_buttons(1'b0, 1'b1);
    send_velocity(16'd0, 16'd0);
    send_buttons(1'b0, 1'b1);
    send_buttons(1'b0, 1'b0);
    send_velocity(16'h7fff, 16'd0);
    send_buttons(1'b1, 1'b0);
    send_velocity(16'h7fff, 16'h7fff);
    send_velocity(16'h0001, 16'h8000);
    send_velocity(16'h8000, 16'd0);
    send_velocity(16'h8000, 16'h0001);
    send_velocity(16'd0, 16'h7fff);
    send_velocity(16'd0, 16'h8000);
    send_speed(OP_SPEED_R, 16'd100);
    send_velocity(16'd0, 16'd5000);
    send_velocity(-16'sd1000, 16'd0);
    send_speed(OP_SPEED_R, 16'h8000);
    send_velocity(16'd20000, 16'd0);
    send_speed(OP_SPEED_L, 16'h7fff);
    send_velocity(16'd0, 16'd0);
    send_speed(OP_SPEED_R, 16'd0);
    send_speed(OP_SPEED_L, 16'd0);
    send_velocity(16'd0, 16'd0);
    send_buttons(1'b0, 1'b0);
    send_velocity(16'd16384, -16'sd16384);
  endtask

  initial begin : rx_pattern
    int seg_left, mode, hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    m_ready   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom);
          2: m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    s_user      = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    burst_left  = 0;
    holdoff_req = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: ;
        1: apply_settings('1, '1, '1, '1, '1);
        2: apply_settings('0, '0, '0, '0, '0);
        3: apply_settings('0, '1, '0, '1, RegW'($urandom));
        4: begin
          apply_settings(RegW'($urandom), RegW'($urandom), RegW'($urandom),
                         RegW'($urandom), RegW'($urandom));
          // indexes past the last register must be ignored
          for (int k = 1; k <= 3; k++)
            write_reg(CfgIdxW'(CFG_IDLE_LEVEL) + CfgIdxW'(k), RegW'($urandom));
        end
        5: apply_settings(RegW'($urandom), RegW'($urandom), RegW'($urandom),
                          RegW'($urandom), RegW'($urandom_range(0, 40)));
        default: apply_settings(NormalGainRst, TurboGainRst, DriveOffsetRst,
                                SpinGainRst, IdleLevelRst);
      endcase
      for (int n = 0; n < 230; n++) begin
        if ((phase == 1 || phase == 4) && n == 50) holdoff_req = 1'b1;
        random_event();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== diff_drive_command_mixer_core.f =====
rtl/ddcm_pkg.sv
rtl/diff_drive_command_mixer_core.sv
tb/ddcm_checker.sv
tb/diff_drive_command_mixer_core_test.sv
